/* hdl/iag_pkg.sv */
`default_nettype none
package iag_pkg;

  // Field and register widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 41;
  localparam int GSUM_W    = 40;
  localparam int MEAN_W    = 16;
  localparam int COUNT_W   = 24;
  localparam int VSQ_W     = 16;   // floor((dx^2 + dy^2) / 2) fits here

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Handshake between the sequencer and a multi-cycle unit
  typedef struct packed {
    logic start;
    logic done;
  } iag_unit_ctl_t;

endpackage
`default_nettype wire

/* hdl/iag_sqrt.sv */
`default_nettype none
// Digit-by-digit integer square root, one root bit per cycle.
module iag_sqrt import iag_pkg::*; #(
  parameter int RW = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [2*RW-1:0] radicand,
  output logic                 done,
  output logic [RW-1:0]        root
);

  localparam int CNT_W = $clog2(RW + 1);

  logic [2*RW-1:0] rad;
  logic [RW+1:0]   rem;
  logic [RW-1:0]   res;
  logic [CNT_W-1:0] cnt;
  logic            busy;

  logic [RW+3:0] rem_shift;
  logic [RW+3:0] trial;
  logic          fits;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_shift = {rem, rad[2*RW-1 -: 2]};
    trial     = (RW+4)'({res, 2'b01});
    fits      = rem_shift >= trial;
  end

  assign done = busy && (cnt == CNT_W'(RW - 1));
  assign root = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= !done;
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      if (fits) begin
        rem <= (RW+2)'(rem_shift - trial);
        res <= {res[RW-2:0], 1'b1};
      end else begin
        rem <= (RW+2)'(rem_shift);
        res <= {res[RW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/iag_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module iag_div import iag_pkg::*; #(
  parameter int DW = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] dvd;   // dividend shifts out, quotient shifts in
  logic [DW-1:0]    dvs;
  logic [DW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DW:0] rem_shift;
  logic        fits;

  always_comb begin
    rem_shift = {rem, dvd[SUM_W-1]};
    fits      = rem_shift >= {1'b0, dvs};
  end

  assign done     = busy && (cnt == CNT_W'(SUM_W - 1));
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= !done;
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DW'(rem_shift - {1'b0, dvs});
        dvd <= {dvd[SUM_W-2:0], 1'b1};
      end else begin
        rem <= DW'(rem_shift);
        dvd <= {dvd[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/image_average_gradient.sv */
`default_nettype none
// Average-gradient sharpness meter. Feed 8-bit grayscale pixels in raster
// order; frame_width and frame_height (clamped to 2..MAX) set the frame size,
// and a write to either of them restarts the frame. One item is taken at a
// time: a pixel in the first row or column passes through the difference
// state, and a pixel that closes a pair also runs the square-root unit that
// yields one result bit per cycle. The last pixel of a frame then goes on
// to the count state and the 41-step divider before the result is loaded
// into the output register, which then waits for out_ready while pixels of
// the next frame are taken. The previous row lives in a MAX_WIDTH-entry
// memory with registered read data.
module image_average_gradient import iag_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [MEAN_W-1:0]         mean_gradient,
  output logic [GSUM_W-1:0]         gradient_sum,
  output logic [COUNT_W-1:0]        pair_count
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RCW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW + HW;
  localparam int RW = 8 + FRAC_BITS;
  localparam int RAD_W = 2 * RW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIFF  = 7'b0000010,
    S_ROOT  = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_COUNT = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [CW-1:0]    col;
  logic [RCW-1:0]   row;
  logic [PIX_W-1:0] left_pixel, upper_left, cur_pixel;
  logic [SUM_W-1:0] running_sum, sum_hold;
  logic [PW-1:0]    count_hold;
  logic             pair_flag, last_flag;

  logic [PIX_W-1:0] row_store [MAX_WIDTH];
  logic [PIX_W-1:0] top;

  logic [VSQ_W-1:0] vsq;
  iag_unit_ctl_t    sq_ctl, div_ctl;
  logic [RW-1:0]    root;
  logic [SUM_W-1:0] quot;

  // Effective frame size
  logic [31:0] w32, h32, cw32, ch32;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  always_comb begin
    cw32 = 32'(frame_width);
    ch32 = 32'(frame_height);
    w32 = (cw32 < 32'd2) ? 32'd2 : (cw32 > MAX_WIDTH) ? 32'(MAX_WIDTH) : cw32;
    h32 = (ch32 < 32'd2) ? 32'd2 : (ch32 > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : ch32;
    w_eff = WW'(w32);
    h_eff = HW'(h32);
  end

  // Raster position of the incoming pixel
  logic [CW-1:0]  col_cur;
  logic [RCW-1:0] row_cur;
  logic           col_wrap, row_wrap;
  always_comb begin
    col_cur  = (32'(col) >= w32) ? '0 : col;
    row_cur  = (32'(row) >= h32) ? '0 : row;
    col_wrap = (32'(col_cur) + 32'd1) >= w32;
    row_wrap = (32'(row_cur) + 32'd1) >= h32;
  end

  logic accept;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Line store: read-first, one access per accepted pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      top            <= row_store[col_cur];
      row_store[col_cur] <= pixel;
    end
  end

  // Squared differences against the pixel above-left
  logic [PIX_W-1:0] adx, ady;
  logic [16:0]      sq_sum;
  always_comb begin
    adx    = (top >= upper_left) ? top - upper_left : upper_left - top;
    ady    = (left_pixel >= upper_left) ? left_pixel - upper_left
                                        : upper_left - left_pixel;
    sq_sum = 17'(16'(adx) * 16'(adx)) + 17'(16'(ady) * 16'(ady));
  end

  assign sq_ctl.start  = (state == S_DIFF) && pair_flag;
  assign div_ctl.start = (state == S_COUNT);

  // Pair count of the effective frame
  logic [PW-1:0] count_now;
  assign count_now = PW'(32'(w_eff - WW'(1)) * 32'(h_eff - HW'(1)));

  iag_sqrt #(.RW(RW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_ctl.start),
    .radicand (RAD_W'(vsq) << (2 * FRAC_BITS)),
    .done     (sq_ctl.done),
    .root     (root)
  );

  iag_div #(.DW(PW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctl.start),
    .dividend (running_sum),
    .divisor  (count_now),
    .done     (div_ctl.done),
    .quotient (quot)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_DIFF;
      S_DIFF:  state_next = pair_flag ? S_ROOT : (last_flag ? S_COUNT : S_IDLE);
      S_ROOT:  if (sq_ctl.done) state_next = S_ACC;
      S_ACC:   state_next = last_flag ? S_COUNT : S_IDLE;
      S_COUNT: state_next = S_DIV;
      S_DIV:   if (div_ctl.done) state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // vsq is computed from the same-cycle sq_sum when the root starts
  assign vsq = sq_sum[16:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= CFG_W'(640);
      frame_height <= CFG_W'(480);
      col          <= '0;
      row          <= '0;
      left_pixel   <= '0;
      upper_left   <= '0;
      running_sum  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
        else frame_height <= cfg_data;
        col         <= '0;
        row         <= '0;
        left_pixel  <= '0;
        upper_left  <= '0;
        running_sum <= '0;
      end else begin
        if (accept) begin
          col <= col_wrap ? '0 : col_cur + CW'(1);
          row <= col_wrap ? (row_wrap ? '0 : row_cur + RCW'(1)) : row_cur;
        end
        if (state == S_DIFF) begin
          upper_left <= top;
          left_pixel <= cur_pixel;
        end
        if (state == S_ACC) running_sum <= running_sum + SUM_W'(root);
        if (state == S_COUNT) running_sum <= '0;
      end

      // Result register: load a new result, else drop on handshake
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Per-item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_pixel <= pixel;
      pair_flag <= (row_cur != '0) && (col_cur != '0);
      last_flag <= col_wrap && row_wrap;
    end
    if (state == S_COUNT) begin
      sum_hold   <= running_sum;
      count_hold <= count_now;
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      mean_gradient <= quot[MEAN_W-1:0];
      gradient_sum  <= sum_hold[GSUM_W-1:0];
      pair_count    <= COUNT_W'(count_hold);
    end
  end

  // Checks
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    32'(col) < w32) else $error("column position beyond frame width");
  a_root_in_root: assert property (@(posedge clk) disable iff (rst)
    sq_ctl.done |-> state == S_ROOT) else $error("root finished outside root state");
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_ctl.done |-> state == S_DIV) else $error("divide finished outside divide state");
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_COUNT |=> running_sum == '0) else $error("sum not cleared at frame end");

endmodule
`default_nettype wire
